// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the reflection filter.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ESRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ESRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/esrf_pkg.sv =====
// Package of the reflection filter: widths, register codes, shared types and helpers.
// Depends on nothing; used by every module of the filter.
`default_nettype none

package esrf_pkg;

  localparam int INDEX_BITS = 10;
  localparam int FRAC_BITS  = 16;

  localparam int ENTRY_W   = FRAC_BITS + 2;
  localparam int BASIS_W   = 3 * ENTRY_W;
  localparam int PROD_W    = ENTRY_W + INDEX_BITS;
  localparam int PNT_W     = PROD_W + 2;
  localparam int COORD_W   = 32;
  localparam int EXT_W     = (PNT_W > COORD_W) ? PNT_W : COORD_W;
  localparam int OFF_W     = EXT_W + 1;
  localparam int SQ_W      = 2 * OFF_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int SHORT_W   = 31;
  localparam int BOUND_W   = 64;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int LATENCY   = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_BASIS_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASIS_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASIS_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_LIMITS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_YZ_LONG   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_R   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_SQ   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SQ  = 3'd7;

  typedef struct packed {
    logic [BASIS_W-1:0]        basis_a;
    logic [BASIS_W-1:0]        basis_b;
    logic [BASIS_W-1:0]        basis_c;
    logic signed [COORD_W-1:0] max_x_pos;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_yz;
    logic signed [COORD_W-1:0] long_r;
    logic [SHORT_W-1:0]        short_r;
    logic [BOUND_W-1:0]        long_sq;
    logic [BOUND_W-1:0]        short_sq;
  } cfg_t;

  typedef struct packed {
    logic signed [PNT_W-1:0] x;
    logic signed [PNT_W-1:0] y;
    logic signed [PNT_W-1:0] z;
  } pnt_t;

  typedef struct packed {
    pnt_t            pnt;
    logic            box_ok;
    logic            nonzero;
    logic [SQ_W-1:0] sq_y;
    logic [SQ_W-1:0] sq_z;
    logic [SQ_W-1:0] sq_xl;
    logic [SQ_W-1:0] sq_xs;
    logic [SQ_W-1:0] sq_lim;
  } sq_t;

  function automatic logic signed [ENTRY_W-1:0] entry_of(input logic [BASIS_W-1:0] col,
                                                         input int sel);
    return $signed(col[sel*ENTRY_W +: ENTRY_W]);
  endfunction

  function automatic logic [OFF_W-1:0] mag_of(input logic signed [OFF_W-1:0] v);
    return v[OFF_W-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  function automatic logic signed [COORD_W-1:0] to_coord(input logic signed [PNT_W-1:0] v);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(v);
    return $signed(e[COORD_W-1:0]);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ewald_sphere_reflection_filter.sv =====
// Top level of the reflection filter: configuration registers and the six-stage pipeline.
// Depends on esrf_pkg, esrf_project, esrf_square, esrf_judge and assert_macros.svh.
//
//   Channel   Handshake               Payload
//   input     start, busy             in_index_h, in_index_k, in_index_l
//   result    out_valid (strobe)      out_accepted, out_peak_x, out_peak_y, out_peak_z
//   config    cfg_we                  cfg_index, cfg_wdata
//
// One request is taken every cycle while busy is low.
// The six stages are products, coordinate sums, box tests and offsets, squares,
// lateral sum, then the sphere tests into the result registers.
// Busy is high only during reset; the pipeline never stalls, as results cannot be held off.
// Reset clears the configuration registers and all stage valid bits.
`default_nettype none

module ewald_sphere_reflection_filter (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [esrf_pkg::INDEX_BITS-1:0] in_index_h,
  input  wire logic signed [esrf_pkg::INDEX_BITS-1:0] in_index_k,
  input  wire logic signed [esrf_pkg::INDEX_BITS-1:0] in_index_l,
  output logic                                        out_valid,
  output logic                                        out_accepted,
  output logic signed [esrf_pkg::COORD_W-1:0]         out_peak_x,
  output logic signed [esrf_pkg::COORD_W-1:0]         out_peak_y,
  output logic signed [esrf_pkg::COORD_W-1:0]         out_peak_z,
  input  wire logic                                   cfg_we,
  input  wire logic [esrf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [esrf_pkg::CFG_W-1:0]             cfg_wdata
);

  logic [esrf_pkg::BASIS_W-1:0] basis_a_r;
  logic [esrf_pkg::BASIS_W-1:0] basis_b_r;
  logic [esrf_pkg::BASIS_W-1:0] basis_c_r;
  logic [esrf_pkg::CFG_W-1:0]   x_limits_r;
  logic [esrf_pkg::CFG_W-1:0]   yz_long_r;
  logic [esrf_pkg::SHORT_W-1:0] short_r_r;
  logic [esrf_pkg::BOUND_W-1:0] long_sq_r;
  logic [esrf_pkg::BOUND_W-1:0] short_sq_r;
  esrf_pkg::cfg_t               cfg;
  logic                         in_acc;
  logic                         pnt_vld;
  esrf_pkg::pnt_t               pnt;
  logic                         sq_vld;
  esrf_pkg::sq_t                sq;
  logic                         out_nonzero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      basis_a_r  <= '0;
      basis_b_r  <= '0;
      basis_c_r  <= '0;
      x_limits_r <= '0;
      yz_long_r  <= '0;
      short_r_r  <= '0;
      long_sq_r  <= '0;
      short_sq_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        esrf_pkg::CFG_BASIS_A:  basis_a_r  <= cfg_wdata[esrf_pkg::BASIS_W-1:0];
        esrf_pkg::CFG_BASIS_B:  basis_b_r  <= cfg_wdata[esrf_pkg::BASIS_W-1:0];
        esrf_pkg::CFG_BASIS_C:  basis_c_r  <= cfg_wdata[esrf_pkg::BASIS_W-1:0];
        esrf_pkg::CFG_X_LIMITS: x_limits_r <= cfg_wdata;
        esrf_pkg::CFG_YZ_LONG:  yz_long_r  <= cfg_wdata;
        esrf_pkg::CFG_SHORT_R:  short_r_r  <= cfg_wdata[esrf_pkg::SHORT_W-1:0];
        esrf_pkg::CFG_LONG_SQ:  long_sq_r  <= cfg_wdata[esrf_pkg::BOUND_W-1:0];
        esrf_pkg::CFG_SHORT_SQ: short_sq_r <= cfg_wdata[esrf_pkg::BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.basis_a   = basis_a_r;
    cfg.basis_b   = basis_b_r;
    cfg.basis_c   = basis_c_r;
    cfg.max_x_pos = $signed(x_limits_r[31:0]);
    cfg.max_x     = $signed(x_limits_r[63:32]);
    cfg.max_yz    = $signed(yz_long_r[31:0]);
    cfg.long_r    = $signed(yz_long_r[63:32]);
    cfg.short_r   = short_r_r;
    cfg.long_sq   = long_sq_r;
    cfg.short_sq  = short_sq_r;
  end

  assign busy   = !rst_n;
  assign in_acc = start && !busy;

  esrf_project u_project (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_acc),
    .idx_h   (in_index_h),
    .idx_k   (in_index_k),
    .idx_l   (in_index_l),
    .cfg     (cfg),
    .pnt_vld (pnt_vld),
    .pnt     (pnt)
  );

  esrf_square u_square (
    .clk     (clk),
    .rst_n   (rst_n),
    .pnt_vld (pnt_vld),
    .pnt     (pnt),
    .cfg     (cfg),
    .sq_vld  (sq_vld),
    .sq      (sq)
  );

  esrf_judge u_judge (
    .clk          (clk),
    .rst_n        (rst_n),
    .sq_vld       (sq_vld),
    .sq           (sq),
    .cfg          (cfg),
    .res_vld      (out_valid),
    .res_accepted (out_accepted),
    .res_x        (out_peak_x),
    .res_y        (out_peak_y),
    .res_z        (out_peak_z)
  );

  assign out_nonzero = (out_peak_x != '0) || (out_peak_y != '0) || (out_peak_z != '0);

`include "assert_macros.svh"

  `ESRF_ASSERT_NOW(a_out_has_request, clk, rst_n, out_valid, $past(in_acc, esrf_pkg::LATENCY))
  `ESRF_ASSERT_NOW(a_accept_not_origin, clk, rst_n, out_valid && out_accepted, out_nonzero)
  `ESRF_ASSERT_NOW(a_points_follow_request, clk, rst_n, pnt_vld, $past(in_acc, 2))

endmodule

`default_nettype wire

// ===== rtl/core/esrf_project.sv =====
// Projection stages: nine basis products, then the three coordinate sums.
// Depends on esrf_pkg.
`default_nettype none

module esrf_project (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_vld,
  input  wire logic signed [esrf_pkg::INDEX_BITS-1:0] idx_h,
  input  wire logic signed [esrf_pkg::INDEX_BITS-1:0] idx_k,
  input  wire logic signed [esrf_pkg::INDEX_BITS-1:0] idx_l,
  input  wire esrf_pkg::cfg_t                         cfg,
  output logic                                        pnt_vld,
  output esrf_pkg::pnt_t                              pnt
);

  logic signed [esrf_pkg::PROD_W-1:0] prod_r   [3][3];
  logic signed [esrf_pkg::PROD_W-1:0] prod_nxt [3][3];
  logic signed [esrf_pkg::PNT_W-1:0]  sum_nxt  [3];
  logic                               vld1_r;
  logic                               vld2_r;
  esrf_pkg::pnt_t                     pnt_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i][0] = esrf_pkg::PROD_W'(esrf_pkg::entry_of(cfg.basis_a, i))
                     * esrf_pkg::PROD_W'(idx_h);
      prod_nxt[i][1] = esrf_pkg::PROD_W'(esrf_pkg::entry_of(cfg.basis_b, i))
                     * esrf_pkg::PROD_W'(idx_k);
      prod_nxt[i][2] = esrf_pkg::PROD_W'(esrf_pkg::entry_of(cfg.basis_c, i))
                     * esrf_pkg::PROD_W'(idx_l);
      sum_nxt[i] = esrf_pkg::PNT_W'(prod_r[i][0]) + esrf_pkg::PNT_W'(prod_r[i][1])
                 + esrf_pkg::PNT_W'(prod_r[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    pnt_r.x <= sum_nxt[0];
    pnt_r.y <= sum_nxt[1];
    pnt_r.z <= sum_nxt[2];
  end

  assign pnt_vld = vld2_r;
  assign pnt     = pnt_r;

endmodule

`default_nettype wire

// ===== rtl/core/esrf_square.sv =====
// Box and offset stage, then the squaring stage of the filter.
// Depends on esrf_pkg.
`default_nettype none

module esrf_square (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           pnt_vld,
  input  wire esrf_pkg::pnt_t pnt,
  input  wire esrf_pkg::cfg_t cfg,
  output logic                sq_vld,
  output esrf_pkg::sq_t       sq
);

  logic signed [esrf_pkg::OFF_W-1:0] x_e;
  logic signed [esrf_pkg::OFF_W-1:0] y_e;
  logic signed [esrf_pkg::OFF_W-1:0] z_e;
  logic signed [esrf_pkg::OFF_W-1:0] lim_yz;
  logic                              box_nxt;
  logic                              vld3_r;
  logic                              vld4_r;
  esrf_pkg::pnt_t                    pnt3_r;
  logic                              box3_r;
  logic                              nz3_r;
  logic [esrf_pkg::OFF_W-1:0]        mag_y_r;
  logic [esrf_pkg::OFF_W-1:0]        mag_z_r;
  logic [esrf_pkg::OFF_W-1:0]        mag_xl_r;
  logic [esrf_pkg::OFF_W-1:0]        mag_xs_r;
  logic [esrf_pkg::OFF_W-1:0]        mag_lim_r;
  esrf_pkg::sq_t                     sq_r;

  always_comb begin
    x_e    = esrf_pkg::OFF_W'(pnt.x);
    y_e    = esrf_pkg::OFF_W'(pnt.y);
    z_e    = esrf_pkg::OFF_W'(pnt.z);
    lim_yz = esrf_pkg::OFF_W'(cfg.max_yz);
    box_nxt = (x_e < esrf_pkg::OFF_W'(cfg.max_x_pos))
           && (x_e > -esrf_pkg::OFF_W'(cfg.max_x))
           && (y_e < lim_yz) && (y_e > -lim_yz)
           && (z_e < lim_yz) && (z_e > -lim_yz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld3_r <= pnt_vld;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    pnt3_r    <= pnt;
    box3_r    <= box_nxt;
    nz3_r     <= (pnt.x != '0) || (pnt.y != '0) || (pnt.z != '0);
    mag_y_r   <= esrf_pkg::mag_of(y_e);
    mag_z_r   <= esrf_pkg::mag_of(z_e);
    mag_xl_r  <= esrf_pkg::mag_of(x_e + esrf_pkg::OFF_W'(cfg.long_r));
    mag_xs_r  <= esrf_pkg::mag_of(x_e + esrf_pkg::OFF_W'($signed({1'b0, cfg.short_r})));
    mag_lim_r <= esrf_pkg::mag_of(lim_yz);
  end

  always_ff @(posedge clk) begin
    sq_r.pnt     <= pnt3_r;
    sq_r.box_ok  <= box3_r;
    sq_r.nonzero <= nz3_r;
    sq_r.sq_y    <= esrf_pkg::SQ_W'(mag_y_r) * esrf_pkg::SQ_W'(mag_y_r);
    sq_r.sq_z    <= esrf_pkg::SQ_W'(mag_z_r) * esrf_pkg::SQ_W'(mag_z_r);
    sq_r.sq_xl   <= esrf_pkg::SQ_W'(mag_xl_r) * esrf_pkg::SQ_W'(mag_xl_r);
    sq_r.sq_xs   <= esrf_pkg::SQ_W'(mag_xs_r) * esrf_pkg::SQ_W'(mag_xs_r);
    sq_r.sq_lim  <= esrf_pkg::SQ_W'(mag_lim_r) * esrf_pkg::SQ_W'(mag_lim_r);
  end

  assign sq_vld = vld4_r;
  assign sq     = sq_r;

endmodule

`default_nettype wire

// ===== rtl/core/esrf_judge.sv =====
// Lateral sum and sphere shell stages, ending in the result registers.
// Depends on esrf_pkg.
`default_nettype none

module esrf_judge (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 sq_vld,
  input  wire esrf_pkg::sq_t                        sq,
  input  wire esrf_pkg::cfg_t                       cfg,
  output logic                                      res_vld,
  output logic                                      res_accepted,
  output logic signed [esrf_pkg::COORD_W-1:0]       res_x,
  output logic signed [esrf_pkg::COORD_W-1:0]       res_y,
  output logic signed [esrf_pkg::COORD_W-1:0]       res_z
);

  logic [esrf_pkg::SUM_W-1:0]  tail_nxt;
  logic [esrf_pkg::SUM_W-1:0]  long_sum;
  logic [esrf_pkg::SUM_W-1:0]  short_sum;
  logic                        vld5_r;
  logic                        vld6_r;
  logic [esrf_pkg::SUM_W-1:0]  tail5_r;
  logic                        inner5_r;
  logic                        nz5_r;
  logic [esrf_pkg::SQ_W-1:0]   sq_xl5_r;
  logic [esrf_pkg::SQ_W-1:0]   sq_xs5_r;
  esrf_pkg::pnt_t              pnt5_r;
  logic                        acc6_r;
  logic signed [esrf_pkg::COORD_W-1:0] x6_r;
  logic signed [esrf_pkg::COORD_W-1:0] y6_r;
  logic signed [esrf_pkg::COORD_W-1:0] z6_r;

  always_comb begin
    tail_nxt  = esrf_pkg::SUM_W'(sq.sq_y) + esrf_pkg::SUM_W'(sq.sq_z);
    long_sum  = esrf_pkg::SUM_W'(sq_xl5_r) + tail5_r;
    short_sum = esrf_pkg::SUM_W'(sq_xs5_r) + tail5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else begin
      vld5_r <= sq_vld;
      vld6_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    tail5_r  <= tail_nxt;
    inner5_r <= sq.box_ok && (tail_nxt < esrf_pkg::SUM_W'(sq.sq_lim));
    nz5_r    <= sq.nonzero;
    sq_xl5_r <= sq.sq_xl;
    sq_xs5_r <= sq.sq_xs;
    pnt5_r   <= sq.pnt;
    acc6_r   <= inner5_r && nz5_r
             && (long_sum > esrf_pkg::SUM_W'(cfg.long_sq))
             && (short_sum < esrf_pkg::SUM_W'(cfg.short_sq));
    x6_r     <= esrf_pkg::to_coord(pnt5_r.x);
    y6_r     <= esrf_pkg::to_coord(pnt5_r.y);
    z6_r     <= esrf_pkg::to_coord(pnt5_r.z);
  end

  assign res_vld      = vld6_r;
  assign res_accepted = acc6_r;
  assign res_x        = x6_r;
  assign res_y        = y6_r;
  assign res_z        = z6_r;

endmodule

`default_nettype wire
